// File: sv/expanded_memory_page_manager_macros.svh
// Assertion macros for the expanded memory page manager.
`ifndef EXPANDED_MEMORY_PAGE_MANAGER_MACROS_SVH
`define EXPANDED_MEMORY_PAGE_MANAGER_MACROS_SVH
`define EMPM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define EMPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: sv/empm_pkg.sv
// Package with constants and codes of the expanded memory page manager.
package empm_pkg;
  localparam int TOTAL_PAGES = 128;
  localparam int WINDOWS = 4;
  localparam int HANDLES = 15;
  localparam int PW = $clog2(TOTAL_PAGES);
  localparam int WW = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
  localparam int HW = 4;
  localparam int SW = $clog2(HANDLES * WINDOWS);
  localparam logic [3:0] OWNER_FREE = 4'hF;
  localparam logic [7:0] PAGE_UNMAP = 8'hFF;
  localparam logic [7:0] VERSION_BCD = 8'h32;
  localparam logic [7:0] OP_STATUS = 8'h40;
  localparam logic [7:0] OP_FRAME = 8'h41;
  localparam logic [7:0] OP_COUNTS = 8'h42;
  localparam logic [7:0] OP_ALLOC = 8'h43;
  localparam logic [7:0] OP_MAP = 8'h44;
  localparam logic [7:0] OP_DEALLOC = 8'h45;
  localparam logic [7:0] OP_VERSION = 8'h46;
  localparam logic [7:0] OP_SAVE = 8'h47;
  localparam logic [7:0] OP_RESTORE = 8'h48;
  localparam logic [7:0] OP_HCOUNT = 8'h4B;
  localparam logic [7:0] OP_HPAGES = 8'h4C;
  localparam logic [7:0] OP_HLIST = 8'h4D;
  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_HW = 4'd1;
  localparam logic [3:0] ST_HANDLE = 4'd2;
  localparam logic [3:0] ST_NOFUNC = 4'd3;
  localparam logic [3:0] ST_NOHANDLES = 4'd4;
  localparam logic [3:0] ST_FEWPAGES = 4'd5;
  localparam logic [3:0] ST_ZERO = 4'd6;
  localparam logic [3:0] ST_LOGICAL = 4'd7;
  localparam logic [3:0] ST_PHYSICAL = 4'd8;
  localparam logic [3:0] ST_SAVED = 4'd9;
  localparam logic [3:0] ST_NOSAVE = 4'd10;
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_WINDOW = 2'd1;
  localparam logic [1:0] KIND_LIST = 2'd2;
  localparam logic CFG_HW = 1'b0;
  localparam logic CFG_SEG = 1'b1;
  typedef struct packed {
    logic [7:0] op;
    logic [7:0] window;
    logic [15:0] page_arg;
    logic [7:0] handle;
  } req_t;
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] status;
    logic [15:0] value_b;
    logic [7:0] value_d;
    logic [7:0] version;
    logic [1:0] out_window;
    logic [7:0] out_page;
    logic [3:0] list_handle;
    logic last;
  } rsp_t;
endpackage

// File: sv/empm_if.sv
// Valid/ready channel interface carrying one payload.
interface empm_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: sv/empm_ram.sv
// Generic single-port RAM with registered read.
module empm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: sv/expanded_memory_page_manager.sv
// Expanded memory page manager: one function request at a time, sequenced over
// a page owner RAM with one access per cycle. Allocate scans the 128 page
// owners for a contiguous run, then claims it page by page; without such a run
// it scans all owners again, claiming free pages as it goes. Deallocate checks
// the four windows and then sweeps all 128 owners. After reset a clearing pass
// writes every page owner as free, during which no request is taken. Result
// items leave through an output register, and a stalled output holds the
// sequencer; in_ready is low while a request is served.
module expanded_memory_page_manager
  import empm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_we,
  input  logic  cfg_index,
  input  logic [15:0] cfg_wdata,
  empm_if.sink   in_ch,
  empm_if.source out_ch
);
  localparam logic [4:0] S_CLEAR = 5'd0, S_IDLE = 5'd1, S_DEC = 5'd2, S_EMIT = 5'd3,
    S_ASCAN = 5'd4, S_ARD = 5'd5, S_ACLAIM = 5'd6, S_AFSCAN = 5'd7, S_AFIN = 5'd8,
    S_MRD = 5'd9, S_MCHK = 5'd10, S_DWRD = 5'd11, S_DWCHK = 5'd12, S_DSCAN = 5'd13,
    S_DSRD = 5'd14, S_DFIN = 5'd15, S_SAVE = 5'd16, S_RRD = 5'd17, S_RWAIT = 5'd18,
    S_RWR = 5'd19, S_LIST = 5'd20, S_WAIT = 5'd21;

  logic [4:0] state_r;
  logic [4:0] ret_r;
  logic hw_r;
  logic [15:0] seg_r;
  req_t req_r;
  logic [7:0] wmap_r [WINDOWS];
  logic [7:0] hpages_r [HANDLES];
  logic [HANDLES-1:0] sval_r;
  logic [7:0] free_r;
  logic [3:0] active_r;
  logic [PW:0] idx_r;
  logic [PW-1:0] start_r;
  logic [7:0] run_r;
  logic [7:0] got_r;
  logic [3:0] nh_r;
  logic [7:0] cnt_r;
  rsp_t pend_r;
  rsp_t out_r;
  logic ovalid_r;

  logic pr_we;
  logic [PW-1:0] pr_addr;
  logic [3:0] pr_wdata, pr_rdata;
  logic sr_we;
  logic [SW-1:0] sr_addr;
  logic [7:0] sr_wdata, sr_rdata;

  empm_ram #(.WIDTH(4), .DEPTH(TOTAL_PAGES)) u_owner (
    .clk(clk), .we(pr_we), .addr(pr_addr), .wdata(pr_wdata), .rdata(pr_rdata));
  empm_ram #(.WIDTH(8), .DEPTH(HANDLES * WINDOWS)) u_save (
    .clk(clk), .we(sr_we), .addr(sr_addr), .wdata(sr_wdata), .rdata(sr_rdata));

  logic hok;
  logic [3:0] hh;
  logic [7:0] acount;
  logic [3:0] first_free;
  logic [SW-1:0] sbase;
  logic [WW-1:0] widx;
  assign hh = req_r.handle[3:0];
  assign hok = (req_r.handle < 8'(HANDLES)) && (hpages_r[hh] != 8'd0);
  assign acount = req_r.page_arg[7:0];
  assign sbase = SW'(hh * WINDOWS);
  assign widx = idx_r[WW-1:0];

  always_comb begin
    first_free = 4'(HANDLES);
    for (int i = HANDLES - 1; i >= 1; i--) begin
      if (hpages_r[i] == 8'd0) begin
        first_free = 4'(i);
      end
    end
  end

  always_comb begin
    pr_we = 1'b0;
    pr_addr = idx_r[PW-1:0];
    pr_wdata = OWNER_FREE;
    sr_we = 1'b0;
    sr_addr = sbase + SW'(widx);
    sr_wdata = wmap_r[widx];
    unique case (state_r)
      S_CLEAR: pr_we = 1'b1;
      S_ACLAIM: begin
        pr_we = 1'b1;
        pr_addr = start_r + PW'(got_r);
        pr_wdata = nh_r;
      end
      S_AFIN: begin
        pr_we = (pr_rdata == OWNER_FREE) && (got_r < acount);
        pr_addr = PW'(idx_r - 1'b1);
        pr_wdata = nh_r;
      end
      S_MRD: pr_addr = req_r.page_arg[PW-1:0];
      S_DWRD: pr_addr = wmap_r[widx][PW-1:0];
      S_DFIN: begin
        pr_we = (pr_rdata == hh);
        pr_addr = PW'(idx_r - 1'b1);
      end
      S_SAVE: sr_we = 1'b1;
      default: ;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = out_r;

  function automatic rsp_t fin(logic [3:0] st, logic [15:0] b, logic [7:0] d,
                               logic [7:0] v);
    rsp_t r;
    r = '0;
    r.status = st;
    r.value_b = b;
    r.value_d = d;
    r.version = v;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic rsp_t itm(logic [1:0] k, logic [1:0] w, logic [7:0] p,
                               logic [3:0] lh);
    rsp_t r;
    r = '0;
    r.kind = k;
    r.out_window = w;
    r.out_page = p;
    r.list_handle = lh;
    return r;
  endfunction

  logic obusy;
  logic oload;
  assign obusy = ovalid_r && !out_ch.ready;
  assign oload = (state_r == S_EMIT || state_r == S_WAIT) && !obusy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ret_r <= S_IDLE;
      hw_r <= 1'b1;
      seg_r <= 16'hD000;
      sval_r <= '0;
      free_r <= 8'(TOTAL_PAGES);
      active_r <= '0;
      idx_r <= '0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < WINDOWS; i++) wmap_r[i] <= PAGE_UNMAP;
      for (int i = 0; i < HANDLES; i++) hpages_r[i] <= 8'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HW) hw_r <= cfg_wdata[0];
        else seg_r <= cfg_wdata;
      end
      if (oload) begin
        ovalid_r <= 1'b1;
        out_r <= pend_r;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == (PW+1)'(TOTAL_PAGES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            req_r <= in_ch.data;
            state_r <= S_DEC;
          end
        end
        S_EMIT: if (!obusy) begin
          state_r <= ret_r;
        end
        S_WAIT: if (!obusy) begin
          state_r <= S_IDLE;
        end
        S_DEC: begin
          idx_r <= '0;
          run_r <= '0;
          got_r <= '0;
          cnt_r <= '0;
          nh_r <= first_free;
          state_r <= S_WAIT;
          if (!hw_r && (req_r.op == OP_STATUS || req_r.op == OP_FRAME ||
              req_r.op == OP_COUNTS || req_r.op == OP_ALLOC || req_r.op == OP_MAP ||
              req_r.op == OP_VERSION || req_r.op == OP_HCOUNT ||
              req_r.op == OP_HLIST)) begin
            pend_r <= fin(ST_HW, '0, '0, '0);
          end else begin
            case (req_r.op)
              OP_STATUS: pend_r <= fin(ST_OK, '0, '0, '0);
              OP_FRAME: pend_r <= fin(ST_OK, seg_r, '0, '0);
              OP_COUNTS: pend_r <= fin(ST_OK, 16'(free_r), 8'(TOTAL_PAGES), '0);
              OP_VERSION: pend_r <= fin(ST_OK, '0, '0, VERSION_BCD);
              OP_HCOUNT: pend_r <= fin(ST_OK, 16'(active_r), '0, '0);
              OP_ALLOC: begin
                if (acount == 8'd0) pend_r <= fin(ST_ZERO, '0, '0, '0);
                else if (acount > free_r) pend_r <= fin(ST_FEWPAGES, '0, '0, '0);
                else if (first_free >= 4'(HANDLES))
                  pend_r <= fin(ST_NOHANDLES, '0, '0, '0);
                else state_r <= S_ASCAN;
              end
              OP_MAP: begin
                if (!hok) pend_r <= fin(ST_HANDLE, '0, '0, '0);
                else if (req_r.window >= 8'(WINDOWS))
                  pend_r <= fin(ST_PHYSICAL, '0, '0, '0);
                else if (req_r.page_arg == 16'hFFFF) begin
                  wmap_r[req_r.window[WW-1:0]] <= PAGE_UNMAP;
                  pend_r <= itm(KIND_WINDOW, 2'(req_r.window[WW-1:0]), PAGE_UNMAP, '0);
                  ret_r <= S_MCHK;
                  cnt_r <= 8'd1;
                  state_r <= S_EMIT;
                end else if (req_r.page_arg >= 16'(TOTAL_PAGES))
                  pend_r <= fin(ST_LOGICAL, '0, '0, '0);
                else state_r <= S_MRD;
              end
              OP_DEALLOC: begin
                if (hh == 4'd0 || !hok) pend_r <= fin(ST_HANDLE, '0, '0, '0);
                else state_r <= S_DWRD;
              end
              OP_SAVE: begin
                if (!hok) pend_r <= fin(ST_HANDLE, '0, '0, '0);
                else if (sval_r[hh]) pend_r <= fin(ST_SAVED, '0, '0, '0);
                else state_r <= S_SAVE;
              end
              OP_RESTORE: begin
                if (!hok) pend_r <= fin(ST_HANDLE, '0, '0, '0);
                else if (!sval_r[hh]) pend_r <= fin(ST_NOSAVE, '0, '0, '0);
                else state_r <= S_RRD;
              end
              OP_HPAGES: begin
                if (!hok) pend_r <= fin(ST_HANDLE, '0, '0, '0);
                else pend_r <= fin(ST_OK, 16'(hpages_r[hh]), '0, '0);
              end
              OP_HLIST: state_r <= S_LIST;
              default: pend_r <= fin(ST_NOFUNC, '0, '0, '0);
            endcase
          end
        end
        S_ASCAN: begin
          if (idx_r == (PW+1)'(TOTAL_PAGES)) begin
            idx_r <= '0;
            state_r <= S_AFSCAN;
          end else begin
            state_r <= S_ARD;
          end
        end
        S_ARD: begin
          idx_r <= idx_r + 1'b1;
          state_r <= S_ASCAN;
          if (pr_rdata == OWNER_FREE) begin
            if (run_r == 8'd0) start_r <= idx_r[PW-1:0];
            run_r <= run_r + 1'b1;
            if (run_r + 1'b1 == acount) state_r <= S_ACLAIM;
          end else begin
            run_r <= '0;
          end
        end
        S_ACLAIM: begin
          got_r <= got_r + 1'b1;
          if (got_r + 1'b1 == acount) state_r <= S_AFIN;
          if (got_r + 1'b1 == acount) idx_r <= (PW+1)'(TOTAL_PAGES) + 1'b1;
        end
        S_AFSCAN: begin
          idx_r <= idx_r + 1'b1;
          state_r <= S_AFIN;
        end
        S_AFIN: begin
          if (idx_r > (PW+1)'(TOTAL_PAGES)) begin
            free_r <= free_r - acount;
            hpages_r[nh_r] <= acount;
            sval_r[nh_r] <= 1'b0;
            active_r <= active_r + 1'b1;
            pend_r <= fin(ST_OK, '0, 8'(nh_r), '0);
            state_r <= S_WAIT;
          end else begin
            if (pr_rdata == OWNER_FREE && got_r < acount) got_r <= got_r + 1'b1;
            if (idx_r == (PW+1)'(TOTAL_PAGES)) idx_r <= idx_r + 1'b1;
            else state_r <= S_AFSCAN;
          end
        end
        S_MRD: state_r <= S_MCHK;
        S_MCHK: begin
          state_r <= S_WAIT;
          if (cnt_r != 8'd0) pend_r <= fin(ST_OK, '0, '0, '0);
          else if (pr_rdata != hh) pend_r <= fin(ST_LOGICAL, '0, '0, '0);
          else begin
            wmap_r[req_r.window[WW-1:0]] <= req_r.page_arg[7:0];
            pend_r <= itm(KIND_WINDOW, 2'(req_r.window[WW-1:0]), req_r.page_arg[7:0], '0);
            cnt_r <= 8'd1;
            ret_r <= S_MCHK;
            state_r <= S_EMIT;
          end
        end
        S_DWRD: begin
          if (idx_r == (PW+1)'(WINDOWS)) begin
            idx_r <= '0;
            state_r <= S_DSCAN;
          end else state_r <= S_DWCHK;
        end
        S_DWCHK: begin
          idx_r <= idx_r + 1'b1;
          state_r <= S_DWRD;
          if (wmap_r[widx] != PAGE_UNMAP && wmap_r[widx] < 8'(TOTAL_PAGES) &&
              pr_rdata == hh) begin
            wmap_r[widx] <= PAGE_UNMAP;
            pend_r <= itm(KIND_WINDOW, 2'(widx), PAGE_UNMAP, '0);
            ret_r <= S_DWRD;
            state_r <= S_EMIT;
          end
        end
        S_DSCAN: begin
          idx_r <= idx_r + 1'b1;
          state_r <= S_DFIN;
        end
        S_DFIN: begin
          if (pr_rdata == hh) free_r <= free_r + 1'b1;
          if (idx_r == (PW+1)'(TOTAL_PAGES)) begin
            hpages_r[hh] <= '0;
            sval_r[hh] <= 1'b0;
            active_r <= active_r - 1'b1;
            pend_r <= fin(ST_OK, '0, '0, '0);
            state_r <= S_WAIT;
          end else state_r <= S_DSCAN;
        end
        S_SAVE: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == (PW+1)'(WINDOWS - 1)) begin
            sval_r[hh] <= 1'b1;
            pend_r <= fin(ST_OK, '0, '0, '0);
            state_r <= S_WAIT;
          end
        end
        S_RRD: begin
          if (idx_r == (PW+1)'(WINDOWS)) begin
            sval_r[hh] <= 1'b0;
            pend_r <= fin(ST_OK, '0, '0, '0);
            state_r <= S_WAIT;
          end else state_r <= S_RWAIT;
        end
        S_RWAIT: state_r <= S_RWR;
        S_RWR: begin
          wmap_r[widx] <= sr_rdata;
          pend_r <= itm(KIND_WINDOW, 2'(widx), sr_rdata, '0);
          idx_r <= idx_r + 1'b1;
          ret_r <= S_RRD;
          state_r <= S_EMIT;
        end
        S_LIST: begin
          if (idx_r == (PW+1)'(HANDLES)) begin
            pend_r <= fin(ST_OK, 16'(cnt_r), '0, '0);
            state_r <= S_WAIT;
          end else begin
            idx_r <= idx_r + 1'b1;
            if (hpages_r[idx_r[HW-1:0]] != 8'd0) begin
              cnt_r <= cnt_r + 1'b1;
              pend_r <= itm(KIND_LIST, idx_r[1:0], hpages_r[idx_r[HW-1:0]],
                            idx_r[HW-1:0]);
              ret_r <= S_LIST;
              state_r <= S_EMIT;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "expanded_memory_page_manager_macros.svh"
  `EMPM_ASSERT_IMPL(a_ready_idle, in_ch.ready, !ovalid_r || state_r == S_IDLE)
  `EMPM_ASSERT_NEXT(a_accept_busy, in_ch.valid && in_ch.ready, !in_ch.ready)
  `EMPM_ASSERT_IMPL(a_free_bound, 1'b1, free_r <= 8'(TOTAL_PAGES))
endmodule
